// File: rtl/ima_enc_pkg.sv
// Package for the IMA ADPCM encoder: state types, the step size table and
// the index adjustment table. Depends on nothing; the core and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package ima_enc_pkg;

    // Widths of the sample, code and predictor state.
    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 4;
    localparam int STEP_W   = 15;
    localparam int INDEX_W  = 7;

    // Highest legal step index.
    localparam logic [INDEX_W-1:0] IDX_MAX = 7'd88;

    // Standard 89-entry step size table.
    localparam logic [STEP_W-1:0] QUANT_STEPS [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,
        15'd12,    15'd13,    15'd14,    15'd16,    15'd17,
        15'd19,    15'd21,    15'd23,    15'd25,    15'd28,
        15'd31,    15'd34,    15'd37,    15'd41,    15'd45,
        15'd50,    15'd55,    15'd60,    15'd66,    15'd73,
        15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
        15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
        15'd337,   15'd371,   15'd408,   15'd449,   15'd494,
        15'd544,   15'd598,   15'd658,   15'd724,   15'd796,
        15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,
        15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,
        15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
        15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,
        15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
        15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // Index adjustment by code magnitude.
    localparam logic signed [4:0] IDX_ADJUST [0:7] = '{
        -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
    };

    // Predictor state as seen by the top level.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] predicted_value;
        logic [INDEX_W-1:0]         step_position;
    } ima_enc_state_t;

endpackage

`default_nettype wire

// File: rtl/ima_enc_if.sv
// Handshake channel interfaces for the encoder: PCM samples in, code bytes out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ima_enc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               block_last;

    modport source (output valid, output sample, output block_last, input ready);
    modport sink   (input valid, input sample, input block_last, output ready);
endinterface

interface ima_enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       block_end;

    modport source (output valid, output code_byte, output block_end, input ready);
    modport sink   (input valid, input code_byte, input block_end, output ready);
endinterface

`default_nettype wire

// File: rtl/ima_enc_core.sv
// Predictor and step index registers with the one-sample IMA ADPCM quantiser.
// Depends on ima_enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ima_enc_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire logic signed [ima_enc_pkg::SAMPLE_W-1:0] sample,
    output logic [ima_enc_pkg::CODE_W-1:0]           code,
    output ima_enc_pkg::ima_enc_state_t              status
);
    import ima_enc_pkg::*;

    logic signed [SAMPLE_W-1:0] pred_reg, pred_next;
    logic [INDEX_W-1:0]         index_reg, index_next;

    logic [INDEX_W-1:0]         pos;
    logic [STEP_W-1:0]          step;
    logic signed [SAMPLE_W:0]   diff;
    logic                       neg;
    logic [SAMPLE_W:0]          mag0, mag1, mag2;
    logic [SAMPLE_W:0]          step_x, half_x, qtr_x;
    logic                       bit2, bit1, bit0;
    logic [SAMPLE_W:0]          delta;
    logic signed [SAMPLE_W+1:0] np;
    logic signed [7:0]          ni;

    // Quantise the difference against the current step, one bit at a time.
    always_comb
    begin
        pos    = (index_reg > IDX_MAX) ? IDX_MAX : index_reg;
        step   = QUANT_STEPS[pos];
        step_x = {2'b00, step};
        half_x = {3'b000, step[STEP_W-1:1]};
        qtr_x  = {4'b0000, step[STEP_W-1:2]};

        diff = {sample[SAMPLE_W-1], sample} - {pred_reg[SAMPLE_W-1], pred_reg};
        neg  = diff[SAMPLE_W];
        mag0 = neg ? (-diff) : diff;

        bit2 = (mag0 >= step_x);
        mag1 = bit2 ? (mag0 - step_x) : mag0;
        bit1 = (mag1 >= half_x);
        mag2 = bit1 ? (mag1 - half_x) : mag1;
        bit0 = (mag2 >= qtr_x);

        delta = {5'b00000, step[STEP_W-1:3]}
              + (bit2 ? step_x : '0)
              + (bit1 ? half_x : '0)
              + (bit0 ? qtr_x : '0);

        code = {neg, bit2, bit1, bit0};
    end

    // New predictor, saturated to the signed 16-bit range.
    always_comb
    begin
        if (neg)
            np = {{2{pred_reg[SAMPLE_W-1]}}, pred_reg} - $signed({1'b0, delta});
        else
            np = {{2{pred_reg[SAMPLE_W-1]}}, pred_reg} + $signed({1'b0, delta});
        if (np > 18'sd32767)
            pred_next = 16'sh7FFF;
        else if (np < -18'sd32768)
            pred_next = 16'sh8000;
        else
            pred_next = np[SAMPLE_W-1:0];
    end

    // New step index, clamped to the table.
    always_comb
    begin
        ni = $signed({1'b0, pos}) + 8'(IDX_ADJUST[code[2:0]]);
        if (ni < 8'sd0)
            index_next = '0;
        else if (ni > $signed({1'b0, IDX_MAX}))
            index_next = IDX_MAX;
        else
            index_next = ni[INDEX_W-1:0];
    end

    // State advances once per encoded sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg  <= '0;
            index_reg <= '0;
        end
        else if (advance)
        begin
            pred_reg  <= pred_next;
            index_reg <= index_next;
        end
    end

    assign status.predicted_value = pred_reg;
    assign status.step_position   = index_reg;

endmodule

`default_nettype wire

// File: rtl/ima_adpcm_encoder.sv
// Top level of the IMA ADPCM encoder: input register, nibble packer, result register.
// Depends on ima_enc_pkg, ima_enc_if and ima_enc_core.
//
//  Channel   Dir   Payload                    Beat
//  samples   in    sample[15:0], block_last   one PCM sample
//  codes     out   code_byte[7:0], block_end  two packed 4-bit codes, or one at block end
//
// A sample is registered on acceptance and encoded once the result register can take a
// byte, one sample per cycle sustained while codes is ready; the predictor and index
// loop is combinational. A completed byte is then registered in the result register.
// The result register holds one byte; while a byte waits, an empty input register
// can still take one sample, and both stall when both are full and codes is not ready.
// Reset clears predictor, index, packing state and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module ima_adpcm_encoder (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ima_enc_in_if.sink    samples,
    ima_enc_out_if.source codes
);
    import ima_enc_pkg::*;

    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;

    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg, out_byte_next;
    logic                       out_end_reg, out_end_next;

    logic                       half_full_reg, half_full_next;
    logic [CODE_W-1:0]          held_reg, held_next;

    logic                       fire;
    logic                       emit;
    logic [CODE_W-1:0]          code;
    ima_enc_state_t             status;

    // The registered sample is encoded when the result register can take a byte.
    assign fire          = in_valid_reg && (!out_valid_reg || codes.ready);
    assign samples.ready = !in_valid_reg || fire;

    ima_enc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (fire),
        .sample  (in_sample_reg),
        .code    (code),
        .status  (status)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (samples.ready)
            in_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            in_sample_reg <= samples.sample;
            in_last_reg   <= samples.block_last;
        end
    end

    // Nibble packing: hold the first code, emit on the second or at block end.
    always_comb
    begin
        half_full_next = half_full_reg;
        held_next      = held_reg;
        emit           = 1'b0;
        out_byte_next  = {held_reg, code};
        out_end_next   = in_last_reg;
        if (half_full_reg)
        begin
            emit           = 1'b1;
            out_byte_next  = {code, held_reg};
            out_end_next   = in_last_reg;
            half_full_next = 1'b0;
            held_next      = '0;
        end
        else if (in_last_reg)
        begin
            emit          = 1'b1;
            out_byte_next = {4'b0000, code};
            out_end_next  = 1'b1;
        end
        else
        begin
            half_full_next = 1'b1;
            held_next      = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_full_reg <= 1'b0;
            held_reg      <= '0;
        end
        else if (fire)
        begin
            half_full_reg <= half_full_next;
            held_reg      <= held_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= emit;
        else if (codes.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_byte_reg <= out_byte_next;
            out_end_reg  <= out_end_next;
        end
    end

    assign codes.valid     = out_valid_reg;
    assign codes.code_byte = out_byte_reg;
    assign codes.block_end = out_end_reg;

    // Checks on the encoder's own state.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.step_position <= IDX_MAX)
        else $error("step index left the table");

    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !half_full_reg && !in_last_reg |=> half_full_reg && !out_valid_reg)
        else $error("first code of a pair was not held");

    a_pair_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && half_full_reg |=> !half_full_reg && out_valid_reg)
        else $error("second code of a pair did not produce a byte");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !codes.ready |-> !samples.ready)
        else $error("sample taken while both registers are blocked");

endmodule

`default_nettype wire
